// ===== src/uwd_pkg.sv =====
// Package for the USB water detection controller.
// Holds the event kinds, result codes, queue word and result word types.
// No dependencies.
package uwd_pkg;

    // Event kinds after classification; unknown actions become EV_NONE.
    typedef enum logic [3:0] {
        EV_IRQ       = 4'd0,
        EV_CONN_CHK  = 4'd1,
        EV_WATER_CHK = 4'd2,
        EV_NEGOT_CHK = 4'd3,
        EV_RESTART   = 4'd4,
        EV_POLL_SET  = 4'd5,
        EV_NEGOT_BEG = 4'd6,
        EV_BLANK     = 4'd7,
        EV_UNBLANK   = 4'd8,
        EV_CABLE     = 4'd9,
        EV_TIMER     = 4'd10,
        EV_NONE      = 4'd15
    } event_t;

    // Detection state.
    typedef enum logic [1:0] {
        DET_NONE = 2'd0,
        DET_OR   = 2'd1,
        DET_AND  = 2'd2
    } det_t;

    // Notification codes.
    localparam logic [1:0] NTF_POLL_START = 2'd0;
    localparam logic [1:0] NTF_POLL_STOP  = 2'd1;
    localparam logic [1:0] NTF_WATER_OR   = 2'd2;

    // Power role requests.
    localparam logic [1:0] ROLE_NONE = 2'd0;
    localparam logic [1:0] ROLE_DUAL = 2'd1;
    localparam logic [1:0] ROLE_SINK = 2'd2;

    // Timer commands.
    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_SHORT = 2'd1;
    localparam logic [1:0] TMR_LONG  = 2'd2;
    localparam logic [1:0] TMR_STOP  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_POLL_UNSTOP = 3'd0;
    localparam logic [2:0] CFG_EN_FORCE    = 3'd1;
    localparam logic [2:0] CFG_CABLE_LIMIT = 3'd2;
    localparam logic [2:0] CFG_SHORT_SEC   = 3'd3;
    localparam logic [2:0] CFG_LONG_SEC    = 3'd4;

    // Retry count ceiling.
    localparam logic [3:0] RETRY_MAX = 4'd15;

    // Classified event word passed from front to back.
    typedef struct packed {
        event_t kind;
        logic   or_pin;
        logic   and_pin;
        logic   pin_err;
        logic   role_fail;
        logic   cable;
        logic   target;
    } item_t;

    // One result word.
    typedef struct packed {
        logic       enable_level;
        logic       notify_valid;
        logic [1:0] notify_code;
        logic [1:0] role_request;
        logic [1:0] timer_command;
        logic [7:0] timer_length;
        logic       want_connect_check;
        logic       want_water_check;
        logic       want_negot_check;
        logic       cancel_checks;
        logic [1:0] detect_state;
        logic [3:0] retry_count;
    } result_t;

endpackage

// ===== src/uwd_front.sv =====
// Front stage: accepts input words and classifies the action code.
// Depends on uwd_pkg.
module uwd_front
    import uwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] action,
    input  logic       or_pin,
    input  logic       and_pin,
    input  logic       pin_read_error,
    input  logic       role_fail,
    input  logic       cable_connected,
    input  logic       requested_polling,
    output logic       fe_valid,
    input  logic       fe_ready,
    output item_t      fe_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    // The stage frees up when empty or when its word moves on.
    assign in_ready = !valid_reg || fe_ready;

    // Classify the action; codes past the timer event do nothing.
    always_comb
    begin
        if (action <= EV_TIMER)
        begin
            item_next.kind = event_t'(action);
        end
        else
        begin
            item_next.kind = EV_NONE;
        end
        item_next.or_pin    = or_pin;
        item_next.and_pin   = and_pin;
        item_next.pin_err   = pin_read_error;
        item_next.role_fail = role_fail;
        item_next.cable     = cable_connected;
        item_next.target    = requested_polling;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign fe_valid = valid_reg;
    assign fe_item  = item_reg;

endmodule

// ===== src/uwd_queue.sv =====
// Two-entry queue of classified event words between front and back.
// Depends on uwd_pkg.
module uwd_queue
    import uwd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = entry_reg[rd_ptr_reg];

    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== src/uwd_back.sv =====
// Back stage: holds configuration and controller state, executes one event per
// cycle while the result register is free or being read, and registers the result word. Depends on uwd_pkg.
module uwd_back
    import uwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res_word
);

    // Configuration registers.
    logic       poll_unstop_reg;
    logic       en_force_reg;
    logic [3:0] cable_limit_reg;
    logic [7:0] short_sec_reg;
    logic [7:0] long_sec_reg;

    // Controller state.
    logic       pstop_reg;
    logic       pstop_next;
    det_t       det_reg;
    det_t       det_next;
    logic [3:0] retry_reg;
    logic [3:0] retry_next;
    logic       attached_reg;
    logic       attached_next;
    logic       blank_reg;
    logic       blank_next;
    logic       negp_reg;
    logic       negp_next;
    logic       en_reg;
    logic       en_next;

    // Result register.
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    res_reg;
    result_t    res_next;

    logic       take;
    logic       do_pset;
    logic       pset_tgt;
    logic [3:0] retry_inc;

    assign take    = q_valid && (!out_valid_reg || res_ready);
    assign q_ready = take;

    assign retry_inc = (retry_reg < RETRY_MAX) ? retry_reg + 4'd1 : retry_reg;

    // Event execution.
    always_comb
    begin
        pstop_next    = pstop_reg;
        det_next      = det_reg;
        retry_next    = retry_reg;
        attached_next = attached_reg;
        blank_next    = blank_reg;
        negp_next     = negp_reg;
        en_next       = en_reg;
        res_next      = '0;
        do_pset       = 1'b0;
        pset_tgt      = 1'b0;

        case (q_item.kind)
            EV_IRQ:
            begin
                res_next.cancel_checks = 1'b1;
                if (!q_item.pin_err)
                begin
                    if (q_item.and_pin || det_reg == DET_AND)
                    begin
                        det_next = DET_AND;
                    end
                    else
                    begin
                        det_next = DET_OR;
                    end
                    if (!en_force_reg)
                    begin
                        en_next = 1'b0;
                    end
                    res_next.want_connect_check = 1'b1;
                end
            end
            EV_CONN_CHK:
            begin
                if (!pstop_reg)
                begin
                    if (det_reg == DET_NONE)
                    begin
                        en_next = 1'b1;
                    end
                    else
                    begin
                        if (!poll_unstop_reg)
                        begin
                            res_next.role_request = ROLE_SINK;
                        end
                        if (poll_unstop_reg || !q_item.role_fail)
                        begin
                            en_next = 1'b1;
                            res_next.notify_valid = 1'b1;
                            if (det_reg == DET_OR)
                            begin
                                res_next.notify_code = NTF_WATER_OR;
                                retry_next = retry_inc;
                                if (retry_inc < cable_limit_reg && !blank_reg &&
                                    short_sec_reg != 8'd0)
                                begin
                                    res_next.timer_command = TMR_SHORT;
                                    res_next.timer_length  = short_sec_reg;
                                end
                            end
                            else
                            begin
                                res_next.notify_code = NTF_POLL_STOP;
                                if (!blank_reg && long_sec_reg != 8'd0)
                                begin
                                    res_next.timer_command = TMR_LONG;
                                    res_next.timer_length  = long_sec_reg;
                                end
                            end
                        end
                    end
                end
            end
            EV_WATER_CHK:
            begin
                if (!pstop_reg && !blank_reg)
                begin
                    res_next.role_request = ROLE_DUAL;
                    if (!q_item.role_fail)
                    begin
                        en_next = 1'b1;
                        if (q_item.pin_err)
                        begin
                            retry_next            = 4'd0;
                            res_next.notify_valid = 1'b1;
                            res_next.notify_code  = NTF_POLL_START;
                            det_next              = DET_NONE;
                        end
                        else if (retry_reg == 4'd0)
                        begin
                            if (!q_item.or_pin)
                            begin
                                res_next.notify_valid = 1'b1;
                                res_next.notify_code  = NTF_POLL_START;
                                det_next              = DET_NONE;
                            end
                        end
                        else if (retry_reg < cable_limit_reg)
                        begin
                            if (!q_item.or_pin)
                            begin
                                res_next.want_connect_check = 1'b1;
                                en_next                     = 1'b0;
                            end
                            else if (q_item.and_pin)
                            begin
                                det_next = DET_AND;
                            end
                        end
                    end
                end
            end
            EV_NEGOT_CHK:
            begin
                negp_next = 1'b0;
                if (!pstop_reg || en_force_reg)
                begin
                    if (!pstop_reg)
                    begin
                        res_next.notify_valid = 1'b1;
                        res_next.notify_code  = NTF_POLL_START;
                        en_next               = 1'b1;
                    end
                    res_next.timer_command    = TMR_STOP;
                    retry_next                = 4'd0;
                    res_next.want_water_check = 1'b1;
                end
            end
            EV_RESTART:
            begin
                res_next.timer_command    = TMR_STOP;
                retry_next                = 4'd0;
                res_next.want_water_check = 1'b1;
            end
            EV_POLL_SET:
            begin
                do_pset  = 1'b1;
                pset_tgt = q_item.target;
            end
            EV_NEGOT_BEG:
            begin
                if (!en_force_reg)
                begin
                    en_next = 1'b0;
                end
                res_next.want_negot_check = 1'b1;
                negp_next                 = 1'b1;
            end
            EV_BLANK:
            begin
                blank_next             = 1'b1;
                res_next.timer_command = TMR_STOP;
            end
            EV_UNBLANK:
            begin
                blank_next = 1'b0;
                retry_next = 4'd0;
                if (det_reg != DET_NONE)
                begin
                    res_next.want_water_check = 1'b1;
                end
            end
            EV_CABLE:
            begin
                if (attached_reg != q_item.cable)
                begin
                    attached_next = q_item.cable;
                    do_pset       = 1'b1;
                    pset_tgt      = q_item.cable;
                    // Detach begins a negotiation before polling restarts.
                    if (!q_item.cable)
                    begin
                        if (!en_force_reg)
                        begin
                            en_next = 1'b0;
                        end
                        res_next.want_negot_check = 1'b1;
                        negp_next                 = 1'b1;
                    end
                end
            end
            EV_TIMER:
            begin
                res_next.want_water_check = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Polling start or stop, applied after any negotiation begin.
        if (do_pset && pstop_reg != pset_tgt)
        begin
            pstop_next             = pset_tgt;
            det_next               = DET_NONE;
            res_next.timer_command = TMR_STOP;
            res_next.timer_length  = 8'd0;
            if (!negp_next)
            begin
                if (!pset_tgt)
                begin
                    res_next.notify_valid = 1'b1;
                    res_next.notify_code  = NTF_POLL_START;
                    en_next               = 1'b1;
                end
                else if (!en_force_reg)
                begin
                    retry_next = 4'd0;
                    en_next    = 1'b0;
                end
            end
        end

        res_next.enable_level = en_next;
        res_next.detect_state = det_next;
        res_next.retry_count  = retry_next;
    end

    assign out_valid_next = take ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_unstop_reg <= 1'b0;
            en_force_reg    <= 1'b0;
            cable_limit_reg <= 4'd7;
            short_sec_reg   <= 8'd7;
            long_sec_reg    <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POLL_UNSTOP: poll_unstop_reg <= cfg_data[0];
                CFG_EN_FORCE:    en_force_reg    <= cfg_data[0];
                CFG_CABLE_LIMIT: cable_limit_reg <= cfg_data[3:0];
                CFG_SHORT_SEC:   short_sec_reg   <= cfg_data;
                CFG_LONG_SEC:    long_sec_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Controller state advances with each executed event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstop_reg     <= 1'b0;
            det_reg       <= DET_NONE;
            retry_reg     <= 4'd0;
            attached_reg  <= 1'b0;
            blank_reg     <= 1'b0;
            negp_reg      <= 1'b0;
            en_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pstop_reg    <= pstop_next;
                det_reg      <= det_next;
                retry_reg    <= retry_next;
                attached_reg <= attached_next;
                blank_reg    <= blank_next;
                negp_reg     <= negp_next;
                en_reg       <= en_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_word  = res_reg;

endmodule

// ===== src/usb_water_detect_controller_top.sv =====
// USB-port water detection controller, top level.
// Uses uwd_pkg, uwd_front, uwd_queue and uwd_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one event word: action code,
//   detector pin levels and status bits. Output channel (out_valid/out_ready)
//   gives exactly one result word per event, in order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the five control registers; it is always ready and should only be used
//   while no event is in flight.
// Path: an accepted event is held in the front register, then in a queue
//   entry, and the back then registers its result word.
// Throughput: one event per cycle while out_ready stays high; the back
//   executes one event per cycle against its state registers, which sets that figure.
// Reset: all state returns to polling started, no detection, zero retries,
//   enable line driven high; configuration returns to its defaults.
// Output stall: the result register holds; the queue absorbs two events and
//   the front register one more before in_ready drops.
module usb_water_detect_controller_top
    import uwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] action,
    input  logic       or_pin,
    input  logic       and_pin,
    input  logic       pin_read_error,
    input  logic       role_fail,
    input  logic       cable_connected,
    input  logic       requested_polling,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       enable_level,
    output logic       notify_valid,
    output logic [1:0] notify_code,
    output logic [1:0] role_request,
    output logic [1:0] timer_command,
    output logic [7:0] timer_length,
    output logic       want_connect_check,
    output logic       want_water_check,
    output logic       want_negot_check,
    output logic       cancel_checks,
    output logic [1:0] detect_state,
    output logic [3:0] retry_count
);

    logic    fe_valid;
    logic    fe_ready;
    item_t   fe_item;
    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    result_t res_word;

    assign cfg_ready = 1'b1;

    // Front: accept and classify.
    uwd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .or_pin            (or_pin),
        .and_pin           (and_pin),
        .pin_read_error    (pin_read_error),
        .role_fail         (role_fail),
        .cable_connected   (cable_connected),
        .requested_polling (requested_polling),
        .fe_valid          (fe_valid),
        .fe_ready          (fe_ready),
        .fe_item           (fe_item)
    );

    // Queue between front and back.
    uwd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_item  (fe_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // Back: execute and register the result.
    uwd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res_word  (res_word)
    );

    // Result word to output ports.
    assign enable_level       = res_word.enable_level;
    assign notify_valid       = res_word.notify_valid;
    assign notify_code        = res_word.notify_code;
    assign role_request       = res_word.role_request;
    assign timer_command      = res_word.timer_command;
    assign timer_length       = res_word.timer_length;
    assign want_connect_check = res_word.want_connect_check;
    assign want_water_check   = res_word.want_water_check;
    assign want_negot_check   = res_word.want_negot_check;
    assign cancel_checks      = res_word.cancel_checks;
    assign detect_state       = res_word.detect_state;
    assign retry_count        = res_word.retry_count;

endmodule

// ===== test/tb_usb_water_detect_controller_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for usb_water_detect_controller_top: directed and random event words,
// predicted results compared per field, random idling on both sides. Depends on uwd_pkg and RTL.
module tb_usb_water_detect_controller_top;
    import uwd_pkg::*;

    // One event word as queued for the driver, with the idle cycles that precede it.
    typedef struct {
        logic [3:0]  act;
        logic        orp;
        logic        andp;
        logic        rd_err;
        logic        refused;
        logic        plugged;
        logic        stop_req;
        int unsigned gap;
    } water_event_t;

    localparam int unsigned WATCHDOG_LIMIT = 4000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [3:0] action = '0;
    logic       or_pin = 1'b0;
    logic       and_pin = 1'b0;
    logic       pin_read_error = 1'b0;
    logic       role_fail = 1'b0;
    logic       cable_connected = 1'b0;
    logic       requested_polling = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       enable_level;
    logic       notify_valid;
    logic [1:0] notify_code;
    logic [1:0] role_request;
    logic [1:0] timer_command;
    logic [7:0] timer_length;
    logic       want_connect_check;
    logic       want_water_check;
    logic       want_negot_check;
    logic       cancel_checks;
    logic [1:0] detect_state;
    logic [3:0] retry_count;

    // Predictor copy of the controller state and its configuration.
    logic       st_stopped = 1'b0;
    det_t       st_det = DET_NONE;
    logic [3:0] st_retries = '0;
    logic       st_attached = 1'b0;
    logic       st_blanked = 1'b0;
    logic       st_negot = 1'b0;
    logic       st_enable = 1'b1;
    logic       cf_unstop = 1'b0;
    logic       cf_force = 1'b0;
    logic [3:0] cf_limit = 4'd7;
    logic [7:0] cf_short = 8'd7;
    logic [7:0] cf_long = 8'd0;

    water_event_t pending_events[$];
    result_t      expected_results[$];
    result_t      nxt_result;
    result_t      seen_word;
    result_t      want_word;
    water_event_t drv_ev;

    int unsigned gap_mode = 0;
    int unsigned ready_mode = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned queued_events = 0;

    usb_water_detect_controller_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .action             (action),
        .or_pin             (or_pin),
        .and_pin            (and_pin),
        .pin_read_error     (pin_read_error),
        .role_fail          (role_fail),
        .cable_connected    (cable_connected),
        .requested_polling  (requested_polling),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .enable_level       (enable_level),
        .notify_valid       (notify_valid),
        .notify_code        (notify_code),
        .role_request       (role_request),
        .timer_command      (timer_command),
        .timer_length       (timer_length),
        .want_connect_check (want_connect_check),
        .want_water_check   (want_water_check),
        .want_negot_check   (want_negot_check),
        .cancel_checks      (cancel_checks),
        .detect_state       (detect_state),
        .retry_count        (retry_count)
    );

    // Free-running clock.
    always #2 clk = ~clk;

    // Random helpers.
    function automatic logic rand_bit(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Idle length: mostly short, now and then long; mode 0 means no idling.
    function automatic int unsigned draw_idle(input int unsigned mode);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
        begin
            if (pick < 70)
                return 0;
            if (pick < 95)
                return $urandom_range(1, 3);
            return $urandom_range(4, 12);
        end
        if (pick < 35)
            return 0;
        if (pick < 75)
            return $urandom_range(1, 4);
        if (pick < 95)
            return $urandom_range(5, 15);
        return $urandom_range(20, 60);
    endfunction

    // Predictor helpers operating on nxt_result and the state copy.
    task automatic notify_host(input logic [1:0] code);
        nxt_result.notify_valid = 1'b1;
        nxt_result.notify_code = code;
    endtask

    task automatic timer_arm(input logic is_long);
        logic [7:0] secs;
        secs = is_long ? cf_long : cf_short;
        if (!st_blanked && secs != 8'd0)
        begin
            nxt_result.timer_command = is_long ? TMR_LONG : TMR_SHORT;
            nxt_result.timer_length = secs;
        end
    endtask

    task automatic timer_halt();
        nxt_result.timer_command = TMR_STOP;
        nxt_result.timer_length = 8'd0;
    endtask

    task automatic recheck_restart();
        timer_halt();
        st_retries = 4'd0;
        nxt_result.want_water_check = 1'b1;
    endtask

    task automatic polling_change(input logic stop_req);
        if (st_stopped != stop_req)
        begin
            st_stopped = stop_req;
            st_det = DET_NONE;
            timer_halt();
            // While negotiation is pending the enable line and host stay untouched.
            if (!st_negot)
            begin
                if (!stop_req)
                begin
                    notify_host(NTF_POLL_START);
                    st_enable = 1'b1;
                end
                else if (!cf_force)
                begin
                    st_retries = 4'd0;
                    st_enable = 1'b0;
                end
            end
        end
    endtask

    task automatic negotiation_start();
        if (!cf_force)
            st_enable = 1'b0;
        nxt_result.want_negot_check = 1'b1;
        st_negot = 1'b1;
    endtask

    // Computes the result word for one event and advances the state copy.
    task automatic predict_water_result(input water_event_t ev);
        nxt_result = '0;
        case (ev.act)
            EV_IRQ:
            begin
                nxt_result.cancel_checks = 1'b1;
                if (!ev.rd_err)
                begin
                    st_det = (ev.andp || st_det == DET_AND) ? DET_AND : DET_OR;
                    if (!cf_force)
                        st_enable = 1'b0;
                    nxt_result.want_connect_check = 1'b1;
                end
            end
            EV_CONN_CHK:
            begin
                if (!st_stopped)
                begin
                    if (st_det == DET_NONE)
                        st_enable = 1'b1;
                    else if (!cf_unstop && ev.refused)
                        nxt_result.role_request = ROLE_SINK;
                    else
                    begin
                        if (!cf_unstop)
                            nxt_result.role_request = ROLE_SINK;
                        if (st_det == DET_OR)
                        begin
                            notify_host(NTF_WATER_OR);
                            if (st_retries != RETRY_MAX)
                                st_retries = st_retries + 4'd1;
                            if (st_retries < cf_limit)
                                timer_arm(1'b0);
                        end
                        else
                        begin
                            notify_host(NTF_POLL_STOP);
                            timer_arm(1'b1);
                        end
                        st_enable = 1'b1;
                    end
                end
            end
            EV_WATER_CHK:
            begin
                if (!st_stopped && !st_blanked)
                begin
                    nxt_result.role_request = ROLE_DUAL;
                    if (!ev.refused)
                    begin
                        st_enable = 1'b1;
                        // A failed pin read counts as a dry port.
                        if (ev.rd_err)
                        begin
                            st_retries = 4'd0;
                            notify_host(NTF_POLL_START);
                            st_det = DET_NONE;
                        end
                        else if (st_retries == 4'd0)
                        begin
                            if (!ev.orp)
                            begin
                                notify_host(NTF_POLL_START);
                                st_det = DET_NONE;
                            end
                        end
                        else if (st_retries < cf_limit)
                        begin
                            if (!ev.orp)
                            begin
                                nxt_result.want_connect_check = 1'b1;
                                st_enable = 1'b0;
                            end
                            else if (ev.andp)
                                st_det = DET_AND;
                        end
                    end
                end
            end
            EV_NEGOT_CHK:
            begin
                st_negot = 1'b0;
                if (!st_stopped)
                begin
                    notify_host(NTF_POLL_START);
                    st_enable = 1'b1;
                    recheck_restart();
                end
                else if (cf_force)
                    recheck_restart();
            end
            EV_RESTART:
                recheck_restart();
            EV_POLL_SET:
                polling_change(ev.stop_req);
            EV_NEGOT_BEG:
                negotiation_start();
            EV_BLANK:
            begin
                st_blanked = 1'b1;
                timer_halt();
            end
            EV_UNBLANK:
            begin
                st_blanked = 1'b0;
                st_retries = 4'd0;
                if (st_det != DET_NONE)
                    nxt_result.want_water_check = 1'b1;
            end
            EV_CABLE:
            begin
                if (st_attached != ev.plugged)
                begin
                    st_attached = ev.plugged;
                    if (ev.plugged)
                        polling_change(1'b1);
                    else
                    begin
                        negotiation_start();
                        polling_change(1'b0);
                    end
                end
            end
            EV_TIMER:
                nxt_result.want_water_check = 1'b1;
            default:
            begin
            end
        endcase
        nxt_result.enable_level = st_enable;
        nxt_result.detect_state = st_det;
        nxt_result.retry_count = st_retries;
    endtask

    // Driver: presents queued words, holds them until accepted, predicts on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                drv_ev.act = action;
                drv_ev.orp = or_pin;
                drv_ev.andp = and_pin;
                drv_ev.rd_err = pin_read_error;
                drv_ev.refused = role_fail;
                drv_ev.plugged = cable_connected;
                drv_ev.stop_req = requested_polling;
                drv_ev.gap = 0;
                predict_water_result(drv_ev);
                expected_results.push_back(nxt_result);
            end
            if (in_valid && !in_ready)
            begin
                // Word still waiting: keep valid and payload steady.
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_events.size() != 0)
            begin
                if (pending_events[0].gap != 0)
                begin
                    hold_left <= pending_events[0].gap - 1;
                    pending_events[0].gap = 0;
                    in_valid <= 1'b0;
                end
                else
                begin
                    drv_ev = pending_events.pop_front();
                    in_valid <= 1'b1;
                    action <= drv_ev.act;
                    or_pin <= drv_ev.orp;
                    and_pin <= drv_ev.andp;
                    pin_read_error <= drv_ev.rd_err;
                    role_fail <= drv_ev.refused;
                    cable_connected <= drv_ev.plugged;
                    requested_polling <= drv_ev.stop_req;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    task automatic check_field(input string fld, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, fld, want, got);
        end
    endtask

    // Monitor: random back-pressure, and every accepted word checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_word.enable_level = enable_level;
                seen_word.notify_valid = notify_valid;
                seen_word.notify_code = notify_code;
                seen_word.role_request = role_request;
                seen_word.timer_command = timer_command;
                seen_word.timer_length = timer_length;
                seen_word.want_connect_check = want_connect_check;
                seen_word.want_water_check = want_water_check;
                seen_word.want_negot_check = want_negot_check;
                seen_word.cancel_checks = cancel_checks;
                seen_word.detect_state = detect_state;
                seen_word.retry_count = retry_count;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with no event outstanding", $realtime);
                end
                else
                begin
                    want_word = expected_results.pop_front();
                    check_field("enable_level", want_word.enable_level, seen_word.enable_level);
                    check_field("notify_valid", want_word.notify_valid, seen_word.notify_valid);
                    check_field("notify_code", want_word.notify_code, seen_word.notify_code);
                    check_field("role_request", want_word.role_request, seen_word.role_request);
                    check_field("timer_command", want_word.timer_command,
                                seen_word.timer_command);
                    check_field("timer_length", want_word.timer_length, seen_word.timer_length);
                    check_field("want_connect_check", want_word.want_connect_check,
                                seen_word.want_connect_check);
                    check_field("want_water_check", want_word.want_water_check,
                                seen_word.want_water_check);
                    check_field("want_negot_check", want_word.want_negot_check,
                                seen_word.want_negot_check);
                    check_field("cancel_checks", want_word.cancel_checks,
                                seen_word.cancel_checks);
                    check_field("detect_state", want_word.detect_state, seen_word.detect_state);
                    check_field("retry_count", want_word.retry_count, seen_word.retry_count);
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (ready_mode != 0 && rand_bit(ready_mode == 1 ? 15 : 40))
            begin
                stall_left <= draw_idle(ready_mode);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_event(input logic [3:0] act, input logic orp, input logic andp,
                               input logic rd_err, input logic refused,
                               input logic plugged, input logic stop_req);
        water_event_t ev;
        ev.act = act;
        ev.orp = orp;
        ev.andp = andp;
        ev.rd_err = rd_err;
        ev.refused = refused;
        ev.plugged = plugged;
        ev.stop_req = stop_req;
        ev.gap = draw_idle(gap_mode);
        pending_events.push_back(ev);
        queued_events++;
    endtask

    // Mostly wet-port sequences (interrupt, connect check, water check, timer), plus loose events.
    task automatic add_random_traffic(input int unsigned count);
        int unsigned start;
        int unsigned laps;
        int unsigned pick;
        logic [3:0]  act;
        start = queued_events;
        while (queued_events - start < count)
        begin
            if (rand_bit(35))
            begin
                laps = rand_bit(20) ? $urandom_range(8, 18) : $urandom_range(1, 5);
                if (rand_bit(50))
                    queue_event(EV_POLL_SET, rand_bit(50), rand_bit(50), 1'b0, 1'b0,
                                rand_bit(50), 1'b0);
                repeat (laps)
                begin
                    queue_event(EV_IRQ, rand_bit(70), rand_bit(25), rand_bit(5), rand_bit(10),
                                rand_bit(50), rand_bit(50));
                    queue_event(EV_CONN_CHK, rand_bit(70), rand_bit(30), rand_bit(5),
                                rand_bit(8), rand_bit(50), rand_bit(50));
                    if (rand_bit(30))
                        queue_event(EV_TIMER, rand_bit(50), rand_bit(50), rand_bit(50),
                                    rand_bit(50), rand_bit(50), rand_bit(50));
                    if (rand_bit(60))
                        queue_event(EV_WATER_CHK, rand_bit(85), rand_bit(35), rand_bit(5),
                                    rand_bit(8), rand_bit(50), rand_bit(50));
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 14)
                    act = EV_IRQ;
                else if (pick < 28)
                    act = EV_CONN_CHK;
                else if (pick < 46)
                    act = EV_WATER_CHK;
                else if (pick < 52)
                    act = EV_NEGOT_CHK;
                else if (pick < 57)
                    act = EV_RESTART;
                else if (pick < 64)
                    act = EV_POLL_SET;
                else if (pick < 69)
                    act = EV_NEGOT_BEG;
                else if (pick < 73)
                    act = EV_BLANK;
                else if (pick < 78)
                    act = EV_UNBLANK;
                else if (pick < 86)
                    act = EV_CABLE;
                else if (pick < 95)
                    act = EV_TIMER;
                else
                    act = 4'($urandom_range(11, 15));
                queue_event(act, rand_bit(70), rand_bit(40), rand_bit(8), rand_bit(8),
                            rand_bit(50), rand_bit(50));
            end
        end
    endtask

    // Waits until every queued word has gone in and every result has come out.
    task automatic drain_all();
        @(negedge clk);
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_POLL_UNSTOP: cf_unstop = val[0];
            CFG_EN_FORCE:    cf_force = val[0];
            CFG_CABLE_LIMIT: cf_limit = val[3:0];
            CFG_SHORT_SEC:   cf_short = val;
            CFG_LONG_SEC:    cf_long = val;
            default:
            begin
            end
        endcase
    endtask

    // One phase: drain, write all registers, then a batch of random traffic.
    task automatic run_phase(input logic unstop, input logic force_en, input logic [3:0] limit,
                             input logic [7:0] short_s, input logic [7:0] long_s,
                             input int unsigned count, input int unsigned gmode,
                             input int unsigned rmode);
        drain_all();
        write_reg(CFG_POLL_UNSTOP, {7'd0, unstop});
        write_reg(CFG_EN_FORCE, {7'd0, force_en});
        write_reg(CFG_CABLE_LIMIT, {4'd0, limit});
        write_reg(CFG_SHORT_SEC, short_s);
        write_reg(CFG_LONG_SEC, long_s);
        @(negedge clk);
        gap_mode = gmode;
        ready_mode = rmode;
        add_random_traffic(count);
    endtask

    // Stimulus sequence and final verdict.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at reset configuration, back to back.
        queue_event(4'd15, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_event(4'd11, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_IRQ, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(EV_IRQ, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_CONN_CHK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_event(EV_CONN_CHK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_WATER_CHK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_CONN_CHK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_TIMER, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_BLANK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_WATER_CHK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_UNBLANK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_WATER_CHK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_event(EV_WATER_CHK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_IRQ, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_RESTART, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_WATER_CHK, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_event(EV_NEGOT_BEG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_POLL_SET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        queue_event(EV_NEGOT_CHK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_POLL_SET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_CABLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_event(EV_CONN_CHK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_CABLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_event(EV_NEGOT_CHK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        // Random phases over several settings, extremes included, with varied idling.
        run_phase(1'b0, 1'b0, 4'd1, 8'd0, 8'd255, 150, 1, 1);
        run_phase(1'b1, 1'b1, 4'd15, 8'd255, 8'd0, 150, 0, 0);
        run_phase(1'b0, 1'b1, 4'd3, 8'd10, 8'd30, 150, 2, 2);
        run_phase(1'b1, 1'b0, 4'd15, 8'd1, 8'd1, 150, 1, 2);
        run_phase(1'b0, 1'b0, 4'd7, 8'd7, 8'd0, 150, 2, 0);
        run_phase(rand_bit(50), rand_bit(50), 4'($urandom_range(1, 15)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 200, 1, 1);

        drain_all();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
